// ===== design/opsieve_pkg.sv =====
// ----------------------------------------------------------------------------
// opsieve_pkg
// Shared sizes, widths and operation codes of the odd-only prime sieve.
// ----------------------------------------------------------------------------
`default_nettype none

package opsieve_pkg;

    // Sieve and list sizes
    localparam int MAX_LIMIT  = 65536;
    localparam int LIST_DEPTH = 8192;
    localparam int MAP_DEPTH  = MAX_LIMIT / 2;

    // Field widths
    localparam int N_W     = 16;                       // sieve limit / prime value
    localparam int IDX_W   = 13;                       // prime index
    localparam int CNT_W   = 14;                       // prime count
    localparam int MAP_AW  = $clog2(MAP_DEPTH);        // map address, one bit per odd
    localparam int LIST_AW = $clog2(LIST_DEPTH);       // list address
    localparam int ROOT_W  = ($clog2(MAX_LIMIT) / 2) + 1; // odd factor i, up to sqrt + 2
    localparam int SQ_W    = 2 * ROOT_W;               // i * i

    // Reset value of the limit register
    localparam logic [N_W-1:0] LIMIT_RESET = N_W'(50000);

    // Operation codes
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_READ  = 1'b1;

endpackage

`default_nettype wire

// ===== design/opsieve_if.sv =====
// ----------------------------------------------------------------------------
// opsieve request / response channels
// Valid-ready channels carrying sieve requests and their responses.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: operation and index
interface opsieve_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [opsieve_pkg::IDX_W-1:0] prime_index;

    modport source (output valid, output operation, output prime_index, input ready);
    modport sink   (input valid, input operation, input prime_index, output ready);
endinterface

// Response channel: prime, index check and current count
interface opsieve_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [opsieve_pkg::N_W-1:0]   prime_value;
    logic                          index_valid;
    logic [opsieve_pkg::CNT_W-1:0] prime_count;

    modport source (output valid, output prime_value, output index_valid,
                    output prime_count, input ready);
    modport sink   (input valid, input prime_value, input index_valid,
                    input prime_count, output ready);
endinterface

`default_nettype wire

// ===== design/odd_only_prime_sieve_unit.sv =====
// ----------------------------------------------------------------------------
// odd_only_prime_sieve_unit
// Odd-only sieve of Eratosthenes over a one-bit composite map, followed by
// compaction of the primes into a list that is read back by index.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+--------------------------------------------
//  i_req     | in  | valid / ready | operation, prime_index
//  o_rsp     | out | valid / ready | prime_value, index_valid, prime_count
//  i_cfg_*   | in  | write enable  | i_cfg_wdata = sieve limit n
//
//  Read request: the list memory is read on the accept and the response
//  register loads from it in S_RESP.
//  Build request: S_CLEAR clears the map, S_SQUARE, S_PROBE and S_TEST take
//  each odd i with i*i <= n, S_MARK marks each multiple of a prime i from i*i,
//  then S_CREAD and S_CWRITE compact each odd below n into the list, all over
//  the single map port. The map is cleared by each build, so reset
//  needs no clearing pass. One request is in work at a time; a response held
//  by the sink stalls only the hand-off of the next response.
// ----------------------------------------------------------------------------
`default_nettype none

module odd_only_prime_sieve_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [opsieve_pkg::N_W-1:0]    i_cfg_wdata,
    opsieve_req_if.sink                   i_req,
    opsieve_rsp_if.source                 o_rsp
);

    localparam int N_W     = opsieve_pkg::N_W;
    localparam int CNT_W   = opsieve_pkg::CNT_W;
    localparam int MAP_AW  = opsieve_pkg::MAP_AW;
    localparam int LIST_AW = opsieve_pkg::LIST_AW;
    localparam int ROOT_W  = opsieve_pkg::ROOT_W;
    localparam int SQ_W    = opsieve_pkg::SQ_W;

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_CLEAR  = 10'b00_0000_0010,
        S_SQUARE = 10'b00_0000_0100,
        S_PROBE  = 10'b00_0000_1000,
        S_TEST   = 10'b00_0001_0000,
        S_MARK   = 10'b00_0010_0000,
        S_LSTART = 10'b00_0100_0000,
        S_CREAD  = 10'b00_1000_0000,
        S_CWRITE = 10'b01_0000_0000,
        S_RESP   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration and working registers
    logic [N_W-1:0]    r_limit;
    logic [N_W-1:0]    r_n;
    logic [ROOT_W-1:0] r_i;
    logic [SQ_W-1:0]   r_sq;
    logic [N_W-1:0]    r_j;
    logic [MAP_AW-1:0] r_addr;
    logic [CNT_W-1:0]  r_count;
    logic              r_op;
    logic              r_idx_ok;

    // Memories
    logic              map_mem  [opsieve_pkg::MAP_DEPTH];
    logic [N_W-1:0]    list_mem [opsieve_pkg::LIST_DEPTH];
    logic              r_map_rd;
    logic [N_W-1:0]    r_list_rd;

    // Response register
    logic              r_out_valid;
    logic [N_W-1:0]    r_out_value;
    logic              r_out_ivalid;
    logic [CNT_W-1:0]  r_out_count;

    // Datapath helpers
    logic              req_fire;
    logic              out_load;
    logic [MAP_AW-1:0] n_half;
    logic [N_W:0]      j_next;
    logic [MAP_AW:0]   k_next;
    logic [MAP_AW-1:0] map_raddr;
    logic              map_we;
    logic [MAP_AW-1:0] map_waddr;
    logic              map_wdata;
    logic              list_we;
    logic [LIST_AW-1:0] list_waddr;
    logic [N_W-1:0]    list_wdata;
    logic              cnt_room;

    assign req_fire = i_req.valid & i_req.ready;
    assign out_load = (r_state == S_RESP) & (~r_out_valid | o_rsp.ready);
    assign n_half   = r_n[N_W-1:1];
    assign j_next   = {1'b0, r_j} + (N_W+1)'({r_i, 1'b0});
    assign k_next   = {1'b0, r_addr} + (MAP_AW+1)'(1);
    assign cnt_room = (r_count < CNT_W'(opsieve_pkg::LIST_DEPTH));

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.prime_value = r_out_value;
    assign o_rsp.index_valid = r_out_ivalid;
    assign o_rsp.prime_count = r_out_count;

    // Map port selection
    always_comb begin
        map_raddr = r_addr;
        map_we    = 1'b0;
        map_waddr = r_addr;
        map_wdata = 1'b0;
        if (r_state == S_PROBE) begin
            map_raddr = MAP_AW'(r_i[ROOT_W-1:1]);
        end
        if (r_state == S_CLEAR) begin
            map_we = 1'b1;
        end else if (r_state == S_MARK) begin
            map_we    = 1'b1;
            map_waddr = r_j[N_W-1:1];
            map_wdata = 1'b1;
        end
    end

    // List write: 2 at slot 0, then each unmarked odd while room remains
    always_comb begin
        list_we    = 1'b0;
        list_waddr = r_count[LIST_AW-1:0];
        list_wdata = {r_addr, 1'b1};
        if (r_state == S_LSTART) begin
            list_we    = 1'b1;
            list_waddr = '0;
            list_wdata = N_W'(2);
        end else if (r_state == S_CWRITE) begin
            list_we = ~r_map_rd & cnt_room;
        end
    end

    // Composite map memory
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        r_map_rd <= map_mem[map_raddr];
    end

    // Prime list memory, read on an accepted request
    always_ff @(posedge i_clk) begin
        if (list_we) begin
            list_mem[list_waddr] <= list_wdata;
        end
        if (req_fire) begin
            r_list_rd <= list_mem[i_req.prime_index];
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = (i_req.operation == opsieve_pkg::OP_BUILD) ? S_CLEAR : S_RESP;
                end
            end
            S_CLEAR: begin
                if (r_addr == n_half) begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: n_state = S_PROBE;
            S_PROBE: begin
                n_state = (r_sq > SQ_W'(r_n)) ? S_LSTART : S_TEST;
            end
            S_TEST: begin
                n_state = r_map_rd ? S_SQUARE : S_MARK;
            end
            S_MARK: begin
                if (j_next > (N_W+1)'(r_n)) begin
                    n_state = S_SQUARE;
                end
            end
            S_LSTART: begin
                n_state = (n_half > MAP_AW'(1)) ? S_CREAD : S_RESP;
            end
            S_CREAD:  n_state = S_CWRITE;
            S_CWRITE: begin
                n_state = (k_next < (MAP_AW+1)'(n_half)) ? S_CREAD : S_RESP;
            end
            S_RESP: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= opsieve_pkg::LIMIT_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (r_state == S_LSTART) begin
                r_count <= CNT_W'(1);
            end else if (list_we && r_state == S_CWRITE) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the sieve loops
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_addr   <= '0;
                r_i      <= ROOT_W'(3);
                r_n      <= r_limit;
                r_op     <= i_req.operation;
                r_idx_ok <= ({1'b0, i_req.prime_index} < r_count);
            end
            S_CLEAR: begin
                r_addr <= r_addr + MAP_AW'(1);
            end
            S_SQUARE: begin
                r_sq <= SQ_W'(r_i) * SQ_W'(r_i);
            end
            S_TEST: begin
                // unmarked i is prime: start marking at i*i
                if (r_map_rd) begin
                    r_i <= r_i + ROOT_W'(2);
                end else begin
                    r_j <= r_sq[N_W-1:0];
                end
            end
            S_MARK: begin
                if (j_next > (N_W+1)'(r_n)) begin
                    r_i <= r_i + ROOT_W'(2);
                end else begin
                    r_j <= j_next[N_W-1:0];
                end
            end
            S_LSTART: begin
                r_addr <= MAP_AW'(1);
            end
            S_CWRITE: begin
                r_addr <= k_next[MAP_AW-1:0];
            end
            default: begin
            end
        endcase
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_count <= r_count;
            if (r_op == opsieve_pkg::OP_READ && r_idx_ok) begin
                r_out_value  <= r_list_rd;
                r_out_ivalid <= 1'b1;
            end else begin
                r_out_value  <= '0;
                r_out_ivalid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/opsieve_checker.sv =====
// ----------------------------------------------------------------------------
// opsieve_checker
// Port-level checks of the prime sieve unit, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module opsieve_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_req_valid,
    input wire                           i_req_ready,
    input wire                           i_rsp_valid,
    input wire                           i_rsp_ready,
    input wire [opsieve_pkg::N_W-1:0]    i_rsp_value,
    input wire                           i_rsp_ivalid,
    input wire [opsieve_pkg::CNT_W-1:0]  i_rsp_count
);

    // one request in work at a time
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while a request is in work");

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_ivalid)
             && $stable(i_rsp_count)))
        else $error("stalled response changed");

    // an invalid index or a build returns zero
    a_zero_on_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ivalid) |-> (i_rsp_value == '0))
        else $error("nonzero value without a valid index");

    // a valid read returns a value above 1 from a nonempty list
    a_valid_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_ivalid) |-> ((i_rsp_count != '0) && (i_rsp_value > 1)))
        else $error("valid read from empty list or value below 2");

endmodule

bind odd_only_prime_sieve_unit opsieve_checker u_opsieve_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_value  (o_rsp.prime_value),
    .i_rsp_ivalid (o_rsp.index_valid),
    .i_rsp_count  (o_rsp.prime_count)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for odd_only_prime_sieve_unit. Requests come from a
// queue and go out in random bursts. Every accepted request runs through an
// in-bench sieve model, and that gives the answer it should return. Answers
// are checked field by field, in order. The sieve limit is changed only
// between phases, once the unit has drained. The limits used cover the tiny
// corners, the reset value, the largest limit and random limits.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RUN_LIMIT = 4000000;     // cycles before the run is abandoned
    localparam int LONG_HOLD = 300;         // long response back-pressure, cycles

    typedef struct packed {
        logic                          op;
        logic [opsieve_pkg::IDX_W-1:0] idx;
    } t_sieve_request;

    typedef struct packed {
        logic [opsieve_pkg::N_W-1:0]   prime_value;
        logic                          index_valid;
        logic [opsieve_pkg::CNT_W-1:0] prime_count;
    } t_sieve_answer;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [opsieve_pkg::N_W-1:0] cfg_wdata;

    opsieve_req_if req_if();
    opsieve_rsp_if rsp_if();

    odd_only_prime_sieve_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // 10-unit clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Requests waiting to go out, and answers waiting to come back
    t_sieve_request sieve_requests[$];
    t_sieve_answer  awaited_answers[$];

    // Sieve model state
    bit                          odd_marked [opsieve_pkg::MAP_DEPTH]; // bit k is 2k+1
    logic [opsieve_pkg::N_W-1:0] prime_table [opsieve_pkg::LIST_DEPTH];
    int unsigned                 list_len = 0;
    logic [opsieve_pkg::N_W-1:0] limit_shadow;

    // Run statistics
    int mismatches   = 0;
    int answers_seen = 0;
    int builds_sent  = 0;
    int reads_sent   = 0;
    int reads_hit    = 0;
    int limits_set   = 0;
    int cycle_count  = 0;

    // Handshake seen at the last rising edge
    logic req_taken = 1'b0;

    // Sender pacing
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver pacing
    int hold_cycles  = 0;
    int next_hold_at = 30;
    int pattern_age  = 0;
    int stall_pct    = 0;

    // ------------------------------------------------------------------------
    // Sieve model
    // ------------------------------------------------------------------------

    // Mark odd composites, then compact 2 and the unmarked odds below n
    function void rebuild_prime_table();
        int unsigned n, i, j, k;
        n = limit_shadow;
        if (n > opsieve_pkg::MAX_LIMIT - 1)
            n = opsieve_pkg::MAX_LIMIT - 1;
        foreach (odd_marked[m])
            odd_marked[m] = 1'b0;
        for (i = 3; i * i <= n; i += 2) begin
            if (!odd_marked[i / 2]) begin
                for (j = i * i; j <= n; j += 2 * i)
                    odd_marked[j / 2] = 1'b1;
            end
        end
        prime_table[0] = opsieve_pkg::N_W'(2);
        list_len = 1;
        for (k = 1; k < n / 2; k++) begin
            if (!odd_marked[k] && list_len < opsieve_pkg::LIST_DEPTH) begin
                prime_table[list_len] = opsieve_pkg::N_W'(2 * k + 1);
                list_len++;
            end
        end
    endfunction

    // Answer to one request; a build updates the table first
    function t_sieve_answer answer_for_request(logic op,
                                               logic [opsieve_pkg::IDX_W-1:0] idx);
        t_sieve_answer a;
        a.prime_value = '0;
        a.index_valid = 1'b0;
        if (op == opsieve_pkg::OP_BUILD) begin
            rebuild_prime_table();
        end else if (idx < list_len) begin
            a.prime_value = prime_table[idx];
            a.index_valid = 1'b1;
        end
        a.prime_count = opsieve_pkg::CNT_W'(list_len);
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function void queue_read(int unsigned idx);
        sieve_requests.push_back('{op: opsieve_pkg::OP_READ,
                                   idx: opsieve_pkg::IDX_W'(idx)});
    endfunction

    // Index is don't-care on a build; drive random bits anyway
    function void queue_build();
        sieve_requests.push_back('{op: opsieve_pkg::OP_BUILD,
                                   idx: opsieve_pkg::IDX_W'($urandom)});
    endfunction

    // Mostly inside the list, some at its edge, some anywhere
    function int unsigned pick_read_index();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return $urandom_range(0, list_len - 1);
        if (roll < 8)
            return list_len - 1 + $urandom_range(0, 2);
        return $urandom_range(0, opsieve_pkg::LIST_DEPTH - 1);
    endfunction

    // Wait until nothing is queued, offered or outstanding; checked at the
    // rising edge, where the driver's last update is already visible
    task automatic wait_idle();
        while (sieve_requests.size() != 0 || req_if.valid || awaited_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Limit register write, only with the unit drained
    task automatic set_limit(logic [opsieve_pkg::N_W-1:0] value);
        wait_idle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we       <= 1'b0;
        limit_shadow  = value;
        limits_set++;
    endtask

    // ------------------------------------------------------------------------
    // Request driver: bursts of random length with random gaps
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : req_driver
        t_sieve_request nxt;
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (gap_left > 0) begin
                req_if.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end else if (sieve_requests.size() > 0) begin
                nxt = sieve_requests.pop_front();
                req_if.valid       <= 1'b1;
                req_if.operation   <= nxt.op;
                req_if.prime_index <= nxt.idx;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response ready: changing stall rate, plus long holds to back up the unit
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : rsp_ready_gen
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else if (answers_seen >= next_hold_at) begin
            rsp_if.ready <= 1'b0;
            hold_cycles  <= LONG_HOLD;
            next_hold_at <= next_hold_at + 70;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
        // new stall rate each time pattern_age runs out, sometimes none at all
        if (pattern_age >= 50) begin
            pattern_age <= 0;
            case ($urandom_range(0, 3))
                0, 1:    stall_pct <= 0;
                2:       stall_pct <= 30;
                default: stall_pct <= 70;
            endcase
        end else begin
            pattern_age <= pattern_age + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on request handshake, check on response handshake
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_sieve_answer want;
        if (rst_n && req_if.valid && req_if.ready) begin
            want = answer_for_request(req_if.operation, req_if.prime_index);
            awaited_answers.push_back(want);
            if (req_if.operation == opsieve_pkg::OP_BUILD) begin
                builds_sent++;
            end else begin
                reads_sent++;
                if (want.index_valid)
                    reads_hit++;
            end
        end
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            answers_seen++;
            if (awaited_answers.size() == 0) begin
                $error("unexpected response: prime_value %0d index_valid %0d prime_count %0d",
                       rsp_if.prime_value, rsp_if.index_valid, rsp_if.prime_count);
                mismatches++;
            end else begin
                want = awaited_answers.pop_front();
                if (rsp_if.prime_value !== want.prime_value) begin
                    $error("prime_value: expected %0d, got %0d",
                           want.prime_value, rsp_if.prime_value);
                    mismatches++;
                end
                if (rsp_if.index_valid !== want.index_valid) begin
                    $error("index_valid: expected %0d, got %0d",
                           want.index_valid, rsp_if.index_valid);
                    mismatches++;
                end
                if (rsp_if.prime_count !== want.prime_count) begin
                    $error("prime_count: expected %0d, got %0d",
                           want.prime_count, rsp_if.prime_count);
                    mismatches++;
                end
            end
        end
        req_taken <= rst_n && req_if.valid && req_if.ready;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned lim;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_if.valid       = 1'b0;
        req_if.operation   = opsieve_pkg::OP_BUILD;
        req_if.prime_index = '0;
        rsp_if.ready       = 1'b0;
        limit_shadow       = opsieve_pkg::LIMIT_RESET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reads with an empty list, then a build at the reset limit
        queue_read(0);
        queue_read(opsieve_pkg::LIST_DEPTH - 1);
        queue_build();
        wait_idle();
        queue_read(0);
        queue_read(1);
        queue_read(list_len - 1);
        queue_read(list_len);
        queue_read(opsieve_pkg::LIST_DEPTH - 1);

        // tiny limits: the list holds only 2
        for (lim = 0; lim <= 3; lim++) begin
            set_limit(opsieve_pkg::N_W'(lim));
            queue_build();
            wait_idle();
            queue_read(0);
            queue_read(1);
        end

        // largest limit, with reads at both ends of the list
        set_limit(opsieve_pkg::N_W'(opsieve_pkg::MAX_LIMIT - 1));
        queue_build();
        wait_idle();
        queue_read(list_len - 1);
        queue_read(list_len);
        queue_read(0);

        // random phases: one large limit, the rest small to keep builds short
        for (int p = 0; p < 5; p++) begin
            lim = (p == 1) ? $urandom_range(20000, opsieve_pkg::MAX_LIMIT - 1)
                           : $urandom_range(3, 4000);
            set_limit(opsieve_pkg::N_W'(lim));
            queue_build();
            wait_idle();
            for (int t = 0; t < 20; t++) begin
                if (lim <= 8000 && $urandom_range(0, 9) == 0)
                    queue_build();
                else
                    queue_read(pick_read_index());
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);

        $display("Covered %0d builds over %0d limit settings and %0d reads, %0d in range.",
                 builds_sent, limits_set, reads_sent, reads_hit);
        $display("%0d responses checked, %0d mismatching fields.", answers_seen, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
